// File: design/cdq_pkg.sv
// Shared types and constants for the circular deque core.
// Holds request codes, beat layouts and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

	// Field widths fixed by the stream layouts.
	localparam int REQ_W      = 3;
	localparam int VAL_W      = 32;
	localparam int CAP_W      = 5;
	localparam int CNT_W      = 5;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 72;

	// Request codes; any other code behaves as a query.
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

	// Controller to datapath.
	typedef struct packed {
		logic cfg_write;
		logic capture;
		logic update;
		logic fetch;
		logic load;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

// File: design/circular_deque_core.sv
// Circular deque core: double-ended queue in a ring store, one result beat per request beat.
// Each request passes update, registered store read and emit before its result beat is
// registered; a new request is taken only once back in idle, as set by the write-then-read
// through the single ring store. A waiting result stalls the emit.
// Reset (arst_n low, asynchronous): capacity min(16, DEPTH), deque empty, no result pending.
// The store contents are not cleared; an entry that was never written never shows in a result.
`timescale 1ns / 1ps

module circular_deque_core #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// Request stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// Bits from low: req_type[2:0], push_value[34:3], zero fill[39:35].
	input  logic [cdq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

	// Result stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// Bits from low: ok[0], front_value[32:1], rear_value[64:33],
	// entry_count[69:65], is_empty[70], is_full[71].
	output logic [cdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

	// Capacity register write. A write empties the deque but keeps the stored data.
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]       cfg_data
);

	// The controller sequences each request; the datapath owns all storage.
	cdq_pkg::cmd_t    cmd;
	cdq_pkg::status_t status;

	cdq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.status        (status),
		.cmd           (cmd)
	);

	// Pointers step with wrap at the capacity by compare and reset. The front entry
	// sits one slot above the head pointer, the rear entry one slot below the tail.
	cdq_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// File: design/cdq_ctrl.sv
// Sequencing controller for the circular deque core.
// Steps each request through update, fetch and emit; uses cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  cdq_pkg::status_t status,
	output cdq_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_UPDATE = 4'b0010,
		ST_FETCH  = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_n;

	always_comb begin
		state_n       = state_q;
		cmd           = '0;
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// A register write takes the idle slot ahead of a request.
				cfg_ready     = 1'b1;
				s_axis_tready = !cfg_valid;
				if (cfg_valid) begin
					cmd.cfg_write = 1'b1;
				end else if (s_axis_tvalid) begin
					cmd.capture = 1'b1;
					state_n     = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_n    = ST_FETCH;
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_n   = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	a_capture_to_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q == ST_UPDATE)
		else $error("accepted beat did not move to update");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> status.out_free)
		else $error("result loaded over an untaken result");

	a_cfg_excludes_capture: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cfg_write |-> !cmd.capture)
		else $error("register write and request taken together");

endmodule

// File: design/cdq_datapath.sv
// Datapath of the circular deque core: ring store, pointers, count, capacity and result register.
// Driven by cdq_ctrl through cdq_pkg::cmd_t; uses cdq_pkg.
`timescale 1ns / 1ps

module cdq_datapath #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cdq_pkg::cmd_t                     cmd,
	output cdq_pkg::status_t                  status,
	input  logic [cdq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic [cdq_pkg::CAP_W-1:0]         cfg_data,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [cdq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

	localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CMP_W     = ((PTR_W > cdq_pkg::CAP_W) ? PTR_W : cdq_pkg::CAP_W) + 1;
	localparam int EXT_W     = (DATA_WIDTH > cdq_pkg::VAL_W) ? DATA_WIDTH : cdq_pkg::VAL_W;
	localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	logic [cdq_pkg::CAP_W-1:0]   cap_q;
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [cdq_pkg::CNT_W-1:0]   count_q;
	logic [cdq_pkg::REQ_W-1:0]   req_q;
	logic signed [cdq_pkg::VAL_W-1:0] value_q;
	logic                        ok_q;
	logic signed [DATA_WIDTH-1:0] rd_front_q;
	logic signed [DATA_WIDTH-1:0] rd_rear_q;
	logic                        out_valid_q;
	logic                        out_ok_q;
	logic [cdq_pkg::VAL_W-1:0]   out_front_q;
	logic [cdq_pkg::VAL_W-1:0]   out_rear_q;
	logic [cdq_pkg::CNT_W-1:0]   out_count_q;
	logic                        out_empty_q;
	logic                        out_full_q;

	logic [cdq_pkg::CAP_W-1:0]   cfg_cap;
	logic                        full;
	logic                        empty;
	logic                        ok_n;
	logic [PTR_W-1:0]            head_n;
	logic [PTR_W-1:0]            tail_n;
	logic [cdq_pkg::CNT_W-1:0]   count_n;
	logic                        we;
	logic [PTR_W-1:0]            waddr;
	logic signed [EXT_W-1:0]     wr_wide;
	logic [DATA_WIDTH-1:0]       wr_data;
	logic signed [EXT_W-1:0]     front_wide;
	logic signed [EXT_W-1:0]     rear_wide;

	function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p,
		input logic [cdq_pkg::CAP_W-1:0] cap);
		logic [CMP_W-1:0] nxt;
		nxt = CMP_W'(p) + CMP_W'(1);
		return (nxt >= CMP_W'(cap)) ? '0 : PTR_W'(nxt);
	endfunction

	function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p,
		input logic [cdq_pkg::CAP_W-1:0] cap);
		logic [cdq_pkg::CAP_W-1:0] last;
		last = cap - cdq_pkg::CAP_W'(1);
		return (p == '0) ? PTR_W'(last) : p - PTR_W'(1);
	endfunction

	// Capacity zero is held as one, anything above the store depth as the depth.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_cap = cdq_pkg::CAP_W'(1);
		end else if (32'(cfg_data) > DEPTH) begin
			cfg_cap = cdq_pkg::CAP_W'(DEPTH);
		end else begin
			cfg_cap = cfg_data;
		end
	end

	assign full  = (count_q == cap_q);
	assign empty = (count_q == '0);

	always_comb begin
		ok_n    = 1'b1;
		head_n  = head_q;
		tail_n  = tail_q;
		count_n = count_q;
		we      = 1'b0;
		waddr   = head_q;
		case (req_q)
			cdq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					ok_n = 1'b0;
				end else begin
					we      = 1'b1;
					waddr   = head_q;
					head_n  = step_down(head_q, cap_q);
					count_n = count_q + cdq_pkg::CNT_W'(1);
				end
			end
			cdq_pkg::REQ_PUSH_REAR: begin
				if (full) begin
					ok_n = 1'b0;
				end else begin
					we      = 1'b1;
					waddr   = tail_q;
					tail_n  = step_up(tail_q, cap_q);
					count_n = count_q + cdq_pkg::CNT_W'(1);
				end
			end
			cdq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					ok_n = 1'b0;
				end else begin
					head_n  = step_up(head_q, cap_q);
					count_n = count_q - cdq_pkg::CNT_W'(1);
				end
			end
			cdq_pkg::REQ_POP_REAR: begin
				if (empty) begin
					ok_n = 1'b0;
				end else begin
					tail_n  = step_down(tail_q, cap_q);
					count_n = count_q - cdq_pkg::CNT_W'(1);
				end
			end
			cdq_pkg::REQ_QUERY: begin
			end
			default: begin
			end
		endcase
	end

	// Values are kept sign extended or cut to the store width, and read back to 32 bits.
	assign wr_wide    = EXT_W'(value_q);
	assign wr_data    = DATA_WIDTH'(wr_wide);
	assign front_wide = EXT_W'(rd_front_q);
	assign rear_wide  = EXT_W'(rd_rear_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cdq_pkg::CAP_W'(CAP_RESET);
			head_q      <= PTR_W'(CAP_RESET - 1);
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cfg_write) begin
				cap_q   <= cfg_cap;
				head_q  <= PTR_W'(cfg_cap - cdq_pkg::CAP_W'(1));
				tail_q  <= '0;
				count_q <= '0;
			end else if (cmd.update) begin
				head_q  <= head_n;
				tail_q  <= tail_n;
				count_q <= count_n;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q   <= s_axis_tdata[cdq_pkg::REQ_W-1:0];
			value_q <= s_axis_tdata[cdq_pkg::REQ_W +: cdq_pkg::VAL_W];
		end
		if (cmd.update) begin
			ok_q <= ok_n;
		end
		if (cmd.load) begin
			out_ok_q    <= ok_q;
			out_front_q <= empty ? '1 : cdq_pkg::VAL_W'(front_wide);
			out_rear_q  <= empty ? '1 : cdq_pkg::VAL_W'(rear_wide);
			out_count_q <= count_q;
			out_empty_q <= empty;
			out_full_q  <= full;
		end
	end

	// Ring store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.update && we) begin
			mem[waddr] <= wr_data;
		end
		if (cmd.fetch) begin
			rd_front_q <= mem[step_up(head_q, cap_q)];
			rd_rear_q  <= mem[step_down(tail_q, cap_q)];
		end
	end

	assign status.out_free = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {out_full_q, out_empty_q, out_count_q,
		out_rear_q, out_front_q, out_ok_q};

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_q)
		else $error("entry count above capacity");

	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(head_q) < CMP_W'(cap_q) && CMP_W'(tail_q) < CMP_W'(cap_q))
		else $error("pointer outside the ring");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> m_axis_tvalid)
		else $error("loaded result not presented");

endmodule

// File: test/deque_result_checker.sv
// Result checker for the circular deque core: mirrors the deque on every accepted request
// and compares each result beat against the oldest predicted status.
// Depends on cdq_pkg for request codes and beat widths.
`timescale 1ns / 1ps

module deque_result_checker #(
	parameter int DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [cdq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [cdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cdq_pkg::CAP_W-1:0]       cfg_data,
	output int                              mismatch_total,
	output int                              results_owed
);

	localparam int PTR_W = $clog2(DEPTH);

	// Same bit order as the result beat: ok sits in bit 0.
	typedef struct packed {
		logic                      is_full;
		logic                      is_empty;
		logic [cdq_pkg::CNT_W-1:0] entry_count;
		logic [cdq_pkg::VAL_W-1:0] rear_value;
		logic [cdq_pkg::VAL_W-1:0] front_value;
		logic                      ok;
	} deque_status_t;

	logic [cdq_pkg::VAL_W-1:0] ring [DEPTH];
	logic [PTR_W-1:0]          head_slot;
	logic [PTR_W-1:0]          tail_slot;
	logic [cdq_pkg::CNT_W-1:0] held;
	logic [cdq_pkg::CAP_W-1:0] cap;
	deque_status_t             status_due [$];
	int                        mism;

	function automatic logic [PTR_W-1:0] slot_up(input logic [PTR_W-1:0] p);
		return (int'(p) + 1 >= int'(cap)) ? '0 : PTR_W'(int'(p) + 1);
	endfunction

	function automatic logic [PTR_W-1:0] slot_down(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(int'(cap) - 1) : p - 1'b1;
	endfunction

	task automatic clear_pointers();
		head_slot = PTR_W'(int'(cap) - 1);
		tail_slot = '0;
		held = '0;
	endtask

	// Applies one request to the mirrored deque and returns the status it should report.
	function automatic deque_status_t apply_request(input logic [cdq_pkg::REQ_W-1:0] req,
			input logic [cdq_pkg::VAL_W-1:0] val);
		deque_status_t st;
		logic          full;
		logic          empty;
		full = (held == cap);
		empty = (held == '0);
		st.ok = 1'b1;
		case (req)
			cdq_pkg::REQ_PUSH_FRONT: begin
				if (full) begin
					st.ok = 1'b0;
				end else begin
					ring[head_slot] = val;
					head_slot = slot_down(head_slot);
					held = held + 1'b1;
				end
			end
			cdq_pkg::REQ_PUSH_REAR: begin
				if (full) begin
					st.ok = 1'b0;
				end else begin
					ring[tail_slot] = val;
					tail_slot = slot_up(tail_slot);
					held = held + 1'b1;
				end
			end
			cdq_pkg::REQ_POP_FRONT: begin
				if (empty) begin
					st.ok = 1'b0;
				end else begin
					head_slot = slot_up(head_slot);
					held = held - 1'b1;
				end
			end
			cdq_pkg::REQ_POP_REAR: begin
				if (empty) begin
					st.ok = 1'b0;
				end else begin
					tail_slot = slot_down(tail_slot);
					held = held - 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (held == '0) begin
			st.front_value = '1;
			st.rear_value = '1;
		end else begin
			st.front_value = ring[slot_up(head_slot)];
			st.rear_value = ring[slot_down(tail_slot)];
		end
		st.entry_count = held;
		st.is_empty = (held == '0);
		st.is_full = (held == cap);
		return st;
	endfunction

	task automatic check_field(input string field, input logic [cdq_pkg::VAL_W-1:0] want,
			input logic [cdq_pkg::VAL_W-1:0] got);
		if (want !== got) begin
			mism++;
			if (mism <= 10) begin
				$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		deque_status_t got;
		deque_status_t want;
		if (!arst_n) begin
			cap = cdq_pkg::CAP_W'((DEPTH < 16) ? DEPTH : 16);
			clear_pointers();
			status_due.delete();
			mism = 0;
			mismatch_total <= 0;
			results_owed <= 0;
		end else begin
			// A capacity write empties the deque; the stored words stay.
			if (cfg_valid && cfg_ready) begin
				if (cfg_data == '0) begin
					cap = cdq_pkg::CAP_W'(1);
				end else if (int'(cfg_data) > DEPTH) begin
					cap = cdq_pkg::CAP_W'(DEPTH);
				end else begin
					cap = cfg_data;
				end
				clear_pointers();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = deque_status_t'(m_axis_tdata);
				if (status_due.size() == 0) begin
					mism++;
					if (mism <= 10) begin
						$display("%0t ns: result beat %h arrived with none outstanding",
							$time, m_axis_tdata);
					end
				end else begin
					want = status_due.pop_front();
					check_field("ok", cdq_pkg::VAL_W'(want.ok), cdq_pkg::VAL_W'(got.ok));
					check_field("front_value", want.front_value, got.front_value);
					check_field("rear_value", want.rear_value, got.rear_value);
					check_field("entry_count", cdq_pkg::VAL_W'(want.entry_count),
						cdq_pkg::VAL_W'(got.entry_count));
					check_field("is_empty", cdq_pkg::VAL_W'(want.is_empty),
						cdq_pkg::VAL_W'(got.is_empty));
					check_field("is_full", cdq_pkg::VAL_W'(want.is_full),
						cdq_pkg::VAL_W'(got.is_full));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				status_due.push_back(apply_request(s_axis_tdata[cdq_pkg::REQ_W-1:0],
					s_axis_tdata[cdq_pkg::REQ_W +: cdq_pkg::VAL_W]));
			end
			mismatch_total <= mism;
			results_owed <= status_due.size();
		end
	end

endmodule

// File: test/circular_deque_core_test.sv
// Top of the circular deque core testbench: clock, reset, request and capacity stimulus,
// random back-pressure and the verdict. Depends on cdq_pkg, circular_deque_core and
// deque_result_checker.
`timescale 1ns / 1ps

module circular_deque_core_test;

	// Codes 5..7 are not defined by the block; it must treat them as a plain query.
	localparam logic [cdq_pkg::REQ_W-1:0] REQ_RESERVED = 3'd7;

	// Far above the slowest legal run: about 2000 requests plus sender gaps and result stalls.
	localparam int CYCLE_LIMIT = 400000;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	// Bits from low: req_type[2:0], push_value[34:3], zero fill[39:35].
	logic [cdq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	// Bits from low: ok[0], front_value[32:1], rear_value[64:33],
	// entry_count[69:65], is_empty[70], is_full[71].
	logic [cdq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cdq_pkg::CAP_W-1:0]       cfg_data = '0;

	// While set, neither the request side nor the result side idles.
	logic                            no_idle = 1'b0;
	int                              mismatch_total;
	int                              results_owed;
	int                              cycles = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	circular_deque_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	deque_result_checker watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatch_total(mismatch_total),
		.results_owed  (results_owed)
	);

	// The result side stalls in roughly 16 percent of cycles. Since the block steps each
	// request through idle, update, fetch and emit, these stalls land on every phase of its work.
	always @(posedge clk) begin
		m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 16);
	end

	// Offers one request beat and returns at the edge that accepts it. The valid is left
	// high so that a following request can go out on the very next cycle.
	task automatic send_request(input logic [cdq_pkg::REQ_W-1:0] req,
			input logic [cdq_pkg::VAL_W-1:0] val);
		int gap;
		gap = 0;
		if (!no_idle && $urandom_range(0, 99) < 16) begin
			gap = $urandom_range(1, 5);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(cdq_pkg::IN_TDATA_W - cdq_pkg::REQ_W - cdq_pkg::VAL_W){1'b0}},
			val, req};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops sending and waits until every predicted result has come back. The first edge
	// lets the checker book a request accepted at the current edge.
	task automatic drain_results(input int extra);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	// Capacity only changes while the deque core is idle.
	task automatic write_capacity(input logic [cdq_pkg::CAP_W-1:0] value);
		drain_results(6);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Push data: mostly random words, now and then one of the sign and magnitude extremes.
	function automatic logic [cdq_pkg::VAL_W-1:0] pick_value();
		if ($urandom_range(0, 7) != 0) begin
			return cdq_pkg::VAL_W'($urandom());
		end
		case ($urandom_range(0, 3))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'hffff_ffff;
			default: return 32'h0000_0000;
		endcase
	endfunction

	// Capacities for the random phases: the clamped values 0, 17 and 31 sit beside the
	// smallest and largest legal ones, and small rings dominate so full and empty recur.
	function automatic logic [cdq_pkg::CAP_W-1:0] capacity_for(input int phase);
		case (phase)
			0: return 5'd1;
			1: return 5'd16;
			2: return 5'd2;
			3: return 5'd31;
			4: return 5'd3;
			5: return 5'd0;
			6: return 5'd7;
			7: return cdq_pkg::CAP_W'($urandom_range(1, 16));
			8: return 5'd17;
			default: return 5'd5;
		endcase
	endfunction

	// One random phase at a given capacity. Every 32 requests the mix leans toward filling,
	// draining or neither, so the deque keeps crossing from empty to full and back and the
	// pointers wrap in both directions. A small share of requests are queries or unknown
	// codes.
	task automatic random_phase(input int count, input logic [cdq_pkg::CAP_W-1:0] capacity,
			input logic pause_midway);
		int                        lean;
		int                        push_pct;
		logic [cdq_pkg::REQ_W-1:0] req;
		lean = 2;
		write_capacity(capacity);
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				lean = $urandom_range(0, 2);
			end
			push_pct = (lean == 0) ? 75 : ((lean == 1) ? 25 : 50);
			if ($urandom_range(0, 99) < 6) begin
				req = cdq_pkg::REQ_QUERY + cdq_pkg::REQ_W'($urandom_range(0, 3));
			end else if ($urandom_range(0, 99) < push_pct) begin
				req = $urandom_range(0, 1) ? cdq_pkg::REQ_PUSH_FRONT : cdq_pkg::REQ_PUSH_REAR;
			end else begin
				req = $urandom_range(0, 1) ? cdq_pkg::REQ_POP_FRONT : cdq_pkg::REQ_POP_REAR;
			end
			// Hold the requests back once until the core has answered everything.
			if (pause_midway && i == count / 2) begin
				drain_results(0);
			end
			send_request(req, pick_value());
		end
	endtask

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity of 16: refused pops on the empty deque, an unknown code, then the
		// value extremes pushed at both ends and popped off again from both ends.
		send_request(cdq_pkg::REQ_QUERY, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'hffff_ffff);
		send_request(cdq_pkg::REQ_POP_REAR, 32'h0000_0000);
		send_request(REQ_RESERVED, 32'h1234_5678);
		send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h7fff_ffff);
		send_request(cdq_pkg::REQ_PUSH_REAR, 32'h8000_0000);
		send_request(cdq_pkg::REQ_PUSH_FRONT, 32'hffff_ffff);
		send_request(cdq_pkg::REQ_PUSH_REAR, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_REAR, 32'hffff_ffff);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_REAR, 32'h0000_0000);

		// Capacity written as zero must behave as a single slot: full after one push.
		write_capacity(5'd0);
		send_request(cdq_pkg::REQ_PUSH_REAR, 32'h1234_5678);
		send_request(cdq_pkg::REQ_PUSH_FRONT, 32'haaaa_5555);
		send_request(cdq_pkg::REQ_POP_REAR, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
		send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h55aa_aaaa);
		send_request(cdq_pkg::REQ_QUERY, 32'hffff_ffff);

		// Two slots: a push to the full ring is refused, then drain from the front.
		write_capacity(5'd2);
		send_request(cdq_pkg::REQ_PUSH_REAR, 32'h0f0f_0f0f);
		send_request(cdq_pkg::REQ_PUSH_REAR, 32'hf0f0_f0f0);
		send_request(cdq_pkg::REQ_PUSH_FRONT, 32'h3333_cccc);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);
		send_request(cdq_pkg::REQ_POP_FRONT, 32'h0000_0000);

		// Random phases of about 200 requests each. Phase 3 runs with no idling on either
		// side; phase 5 holds the requests back once midway.
		for (int phase = 0; phase < 10; phase++) begin
			no_idle <= (phase == 3);
			random_phase(200, capacity_for(phase), phase == 5);
		end
		no_idle <= 1'b0;

		drain_results(10);
		if (mismatch_total == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
